[design/smc2d_pkg.sv]
// Package for the strided multichannel 2D convolution block.
// Field widths, request codes, register indexes and register reset values.
// No dependencies; every other design file but smc2d_ram imports it.
package smc2d_pkg;

  localparam int REQ_W      = 2;
  localparam int CH_W       = 3;
  localparam int POS_W      = 5;
  localparam int VAL_W      = 16;
  localparam int SUM_W      = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam int CC_W  = 4;
  localparam int IMG_W = 6;
  localparam int KER_W = 3;
  localparam int STR_W = 4;

  // Window origin is a position times a stride.
  localparam int BASE_W = POS_W + STR_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_WEIGHT  = 2'd0,
    REQ_PIXEL   = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_e;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_ROWS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_COLS   = 3'd6;

  localparam logic [CC_W-1:0]  RST_CHANNEL_COUNT = 4'd1;
  localparam logic [IMG_W-1:0] RST_IMAGE_ROWS    = 6'd32;
  localparam logic [IMG_W-1:0] RST_IMAGE_COLS    = 6'd32;
  localparam logic [KER_W-1:0] RST_KERNEL_ROWS   = 3'd3;
  localparam logic [KER_W-1:0] RST_KERNEL_COLS   = 3'd3;
  localparam logic [STR_W-1:0] RST_STRIDE_ROWS   = 4'd1;
  localparam logic [STR_W-1:0] RST_STRIDE_COLS   = 4'd1;

endpackage

[design/smc2d_if.sv]
// Valid/ready channel interfaces for the request and result streams.
// Depends on smc2d_pkg for the field widths.
interface smc2d_req_if import smc2d_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [CH_W-1:0]         channel;
  logic [POS_W-1:0]        row;
  logic [POS_W-1:0]        col;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, req_type, channel, row, col, value, input ready);
  modport sink   (input valid, req_type, channel, row, col, value, output ready);
endinterface

interface smc2d_res_if import smc2d_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [POS_W-1:0]        out_row;
  logic [POS_W-1:0]        out_col;
  logic signed [SUM_W-1:0] sum;
  logic                    status;

  modport source (output valid, out_row, out_col, sum, status, input ready);
  modport sink   (input valid, out_row, out_col, sum, status, output ready);
endinterface

[design/smc2d_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module smc2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/strided_multichannel_conv2d.sv]
// Strided multichannel valid 2D cross-correlation, one output position per request.
// Weight and pixel writes produce no result and leave the block ready for the next
// request. A compute request walks channels, kernel rows and kernel columns, reading one
// weight and one pixel per cycle from the two RAMs and accumulating their product exactly
// in 40 bits; the single read port of each memory limits the walk to one tap at a time.
// No further request is taken until its result has been loaded. A request whose window
// leaves the image, or whose sum is empty, skips the walk: it goes from the setup state
// straight to the done state and loads its result there. The result sits in an output
// register, so writes keep flowing while it waits; a further compute stalls only if the
// previous result is still untaken when it finishes. The stores are not cleared at reset.
module strided_multichannel_conv2d import smc2d_pkg::*; #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_ROWS     = 32,
  parameter int MAX_COLS     = 32,
  parameter int MAX_KERNEL   = 7,
  parameter int DATA_WIDTH   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  smc2d_req_if.sink             req_i,
  smc2d_res_if.source           res_o
);

  localparam int SW        = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
  localparam int PW        = 2 * SW;
  localparam int IMG_DEPTH = MAX_CHANNELS * MAX_ROWS * MAX_COLS;
  localparam int WGT_DEPTH = MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int IAW       = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int WAW       = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int NCW       = $clog2(MAX_CHANNELS + 1);
  localparam int KW        = $clog2(MAX_KERNEL + 1);
  localparam int IRW       = $clog2(MAX_ROWS + 1);
  localparam int ICW       = $clog2(MAX_COLS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // Configuration registers.
  logic [CC_W-1:0]  cc_q;
  logic [IMG_W-1:0] ir_q, ic_q;
  logic [KER_W-1:0] kr_q, kc_q;
  logic [STR_W-1:0] sr_q, sc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= RST_CHANNEL_COUNT;
      ir_q <= RST_IMAGE_ROWS;
      ic_q <= RST_IMAGE_COLS;
      kr_q <= RST_KERNEL_ROWS;
      kc_q <= RST_KERNEL_COLS;
      sr_q <= RST_STRIDE_ROWS;
      sc_q <= RST_STRIDE_COLS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CHANNEL_COUNT: cc_q <= cfg_data_i[CC_W-1:0];
        CFG_IMAGE_ROWS:    ir_q <= cfg_data_i[IMG_W-1:0];
        CFG_IMAGE_COLS:    ic_q <= cfg_data_i[IMG_W-1:0];
        CFG_KERNEL_ROWS:   kr_q <= cfg_data_i[KER_W-1:0];
        CFG_KERNEL_COLS:   kc_q <= cfg_data_i[KER_W-1:0];
        CFG_STRIDE_ROWS:   sr_q <= cfg_data_i[STR_W-1:0];
        CFG_STRIDE_COLS:   sc_q <= cfg_data_i[STR_W-1:0];
        default: ;
      endcase
    end
  end

  // Register values clipped to the store sizes.
  logic [NCW-1:0] nc;
  logic [KW-1:0]  kr, kc;
  logic [IRW-1:0] ir;
  logic [ICW-1:0] ic;

  assign nc = (32'(cc_q) > MAX_CHANNELS) ? NCW'(MAX_CHANNELS) : NCW'(cc_q);
  assign kr = (32'(kr_q) > MAX_KERNEL)   ? KW'(MAX_KERNEL)    : KW'(kr_q);
  assign kc = (32'(kc_q) > MAX_KERNEL)   ? KW'(MAX_KERNEL)    : KW'(kc_q);
  assign ir = (32'(ir_q) > MAX_ROWS)     ? IRW'(MAX_ROWS)     : IRW'(ir_q);
  assign ic = (32'(ic_q) > MAX_COLS)     ? ICW'(MAX_COLS)     : ICW'(ic_q);

  // Store writes happen at the request transfer.
  logic           req_fire;
  logic           wgt_we, img_we;
  logic [WAW-1:0] wgt_waddr;
  logic [IAW-1:0] img_waddr;

  assign req_fire = req_i.valid && req_i.ready;

  assign wgt_we = req_fire && (req_i.req_type == REQ_WEIGHT)
               && (32'(req_i.channel) < MAX_CHANNELS)
               && (32'(req_i.row) < MAX_KERNEL) && (32'(req_i.col) < MAX_KERNEL);
  assign img_we = req_fire && (req_i.req_type == REQ_PIXEL)
               && (32'(req_i.channel) < MAX_CHANNELS)
               && (32'(req_i.row) < MAX_ROWS) && (32'(req_i.col) < MAX_COLS);

  assign wgt_waddr = WAW'((32'(req_i.channel) * MAX_KERNEL + 32'(req_i.row)) * MAX_KERNEL
                          + 32'(req_i.col));
  assign img_waddr = IAW'((32'(req_i.channel) * MAX_ROWS + 32'(req_i.row)) * MAX_COLS
                          + 32'(req_i.col));

  // Sequencer and datapath registers.
  logic [2:0]              state_q, state_d;
  logic                    v1_q, v1_d, v2_q, v2_d;
  logic                    out_valid_q, out_valid_d;
  logic [POS_W-1:0]        row_q, row_d, col_q, col_d;
  logic [BASE_W-1:0]       br_q, br_d, bc_q, bc_d;
  logic [NCW-1:0]          c_q, c_d;
  logic [KW-1:0]           a_q, a_d, b_q, b_d;
  logic [WAW-1:0]          w_ch_q, w_ch_d, w_row_q, w_row_d;
  logic [IAW-1:0]          i_ch_q, i_ch_d, i_row_q, i_row_d;
  logic signed [PW-1:0]    prod_q, prod_d;
  logic signed [SUM_W-1:0] acc_q, acc_d;
  logic                    status_q, status_d;
  logic [POS_W-1:0]        res_row_q, res_row_d, res_col_q, res_col_d;
  logic signed [SUM_W-1:0] res_sum_q, res_sum_d;
  logic                    res_status_q, res_status_d;

  logic           rd_en;
  logic [WAW-1:0] wgt_raddr;
  logic [IAW-1:0] img_raddr;
  logic [SW-1:0]  wgt_rdata, img_rdata;
  logic           outside, empty;

  assign rd_en     = (state_q == ST_RUN);
  assign wgt_raddr = w_row_q + WAW'(b_q);
  assign img_raddr = i_row_q + IAW'(b_q);

  assign outside = (32'(br_q) + 32'(kr) > 32'(ir)) || (32'(bc_q) + 32'(kc) > 32'(ic));
  assign empty   = (nc == '0) || (kr == '0) || (kc == '0);

  smc2d_ram #(.WIDTH(SW), .DEPTH(WGT_DEPTH)) u_wgt_ram (
    .clk_i   (clk_i),
    .we_i    (wgt_we),
    .waddr_i (wgt_waddr),
    .wdata_i (req_i.value[SW-1:0]),
    .re_i    (rd_en),
    .raddr_i (wgt_raddr),
    .rdata_o (wgt_rdata)
  );

  smc2d_ram #(.WIDTH(SW), .DEPTH(IMG_DEPTH)) u_img_ram (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i (img_waddr),
    .wdata_i (req_i.value[SW-1:0]),
    .re_i    (rd_en),
    .raddr_i (img_raddr),
    .rdata_o (img_rdata)
  );

  always_comb begin
    state_d      = state_q;
    v1_d         = rd_en;
    v2_d         = v1_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    row_d        = row_q;
    col_d        = col_q;
    br_d         = br_q;
    bc_d         = bc_q;
    c_d          = c_q;
    a_d          = a_q;
    b_d          = b_q;
    w_ch_d       = w_ch_q;
    w_row_d      = w_row_q;
    i_ch_d       = i_ch_q;
    i_row_d      = i_row_q;
    prod_d       = $signed(wgt_rdata) * $signed(img_rdata);
    acc_d        = acc_q;
    status_d     = status_q;
    res_row_d    = res_row_q;
    res_col_d    = res_col_q;
    res_sum_d    = res_sum_q;
    res_status_d = res_status_q;

    if (v2_q) begin
      acc_d = acc_q + {{(SUM_W-PW){prod_q[PW-1]}}, prod_q};
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire && (req_i.req_type == REQ_COMPUTE)) begin
          row_d   = req_i.row;
          col_d   = req_i.col;
          br_d    = BASE_W'(req_i.row) * BASE_W'(sr_q);
          bc_d    = BASE_W'(req_i.col) * BASE_W'(sc_q);
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        acc_d    = '0;
        status_d = outside;
        c_d      = '0;
        a_d      = '0;
        b_d      = '0;
        w_ch_d   = '0;
        w_row_d  = '0;
        i_ch_d   = IAW'(32'(br_q) * MAX_COLS + 32'(bc_q));
        i_row_d  = IAW'(32'(br_q) * MAX_COLS + 32'(bc_q));
        state_d  = (outside || empty) ? ST_DONE : ST_RUN;
      end
      ST_RUN: begin
        if (b_q == kc - KW'(1)) begin
          b_d = '0;
          if (a_q == kr - KW'(1)) begin
            a_d = '0;
            if (c_q == nc - NCW'(1)) begin
              state_d = ST_DRAIN;
            end else begin
              c_d     = c_q + NCW'(1);
              w_ch_d  = w_ch_q + WAW'(MAX_KERNEL * MAX_KERNEL);
              i_ch_d  = i_ch_q + IAW'(MAX_ROWS * MAX_COLS);
              w_row_d = w_ch_q + WAW'(MAX_KERNEL * MAX_KERNEL);
              i_row_d = i_ch_q + IAW'(MAX_ROWS * MAX_COLS);
            end
          end else begin
            a_d     = a_q + KW'(1);
            w_row_d = w_row_q + WAW'(MAX_KERNEL);
            i_row_d = i_row_q + IAW'(MAX_COLS);
          end
        end else begin
          b_d = b_q + KW'(1);
        end
      end
      ST_DRAIN: begin
        // Wait until the last product has landed in the accumulator.
        if (!v1_q && !v2_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d  = 1'b1;
          res_row_d    = row_q;
          res_col_d    = col_q;
          res_sum_d    = acc_q;
          res_status_d = status_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q        <= row_d;
    col_q        <= col_d;
    br_q         <= br_d;
    bc_q         <= bc_d;
    c_q          <= c_d;
    a_q          <= a_d;
    b_q          <= b_d;
    w_ch_q       <= w_ch_d;
    w_row_q      <= w_row_d;
    i_ch_q       <= i_ch_d;
    i_row_q      <= i_row_d;
    prod_q       <= prod_d;
    acc_q        <= acc_d;
    status_q     <= status_d;
    res_row_q    <= res_row_d;
    res_col_q    <= res_col_d;
    res_sum_q    <= res_sum_d;
    res_status_q <= res_status_d;
  end

  assign req_i.ready    = (state_q == ST_IDLE);
  assign res_o.valid    = out_valid_q;
  assign res_o.out_row  = res_row_q;
  assign res_o.out_col  = res_col_q;
  assign res_o.sum      = res_sum_q;
  assign res_o.status   = res_status_q;

endmodule

[design/smc2d_chk.sv]
// Port-level checker for strided_multichannel_conv2d, bound to the top level.
// Depends on smc2d_pkg for the field widths and request codes.
module smc2d_chk import smc2d_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    req_valid_i,
  input logic                    req_ready_i,
  input logic [REQ_W-1:0]        req_type_i,
  input logic                    res_valid_i,
  input logic                    res_ready_i,
  input logic [POS_W-1:0]        res_row_i,
  input logic [POS_W-1:0]        res_col_i,
  input logic signed [SUM_W-1:0] res_sum_i,
  input logic                    res_status_i
);

  // A result that is not taken stays, unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_row_i)
      && $stable(res_col_i) && $stable(res_sum_i) && $stable(res_status_i))
    else $error("result changed while stalled");

  // A window outside the image reports a zero sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i |-> res_sum_i == '0)
    else $error("outside status with nonzero sum");

  // A compute transfer makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_type_i == REQ_COMPUTE |=> !req_ready_i)
    else $error("request taken during compute");

  // Writes and unknown requests leave the block ready for the next transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_type_i != REQ_COMPUTE |=> req_ready_i)
    else $error("write stalled the request channel");

endmodule

bind strided_multichannel_conv2d smc2d_chk u_smc2d_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_type_i   (req_i.req_type),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_row_i    (res_o.out_row),
  .res_col_i    (res_o.out_col),
  .res_sum_i    (res_o.sum),
  .res_status_i (res_o.status)
);

[tb/sv/smc2d_checker.sv]
// Result checker for the strided multichannel 2D convolution block.
// Watches the configuration port and both channels, predicts every window sum and
// compares each result transfer in order. Depends on smc2d_pkg and smc2d_if.
`timescale 1ns / 100ps
module smc2d_checker import smc2d_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  smc2d_req_if                  req_i,
  smc2d_res_if                  res_i,
  output int                    fail_count_o,
  output int                    outstanding_o
);

  localparam int NUM_CH     = 8;
  localparam int NUM_ROWS   = 32;
  localparam int NUM_COLS   = 32;
  localparam int KERNEL_MAX = 7;

  typedef struct packed {
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic signed [SUM_W-1:0] sum;
    logic                    status;
  } out_point_t;

  logic signed [VAL_W-1:0] pixel_mem  [NUM_CH][NUM_ROWS][NUM_COLS];
  logic signed [VAL_W-1:0] weight_mem [NUM_CH][KERNEL_MAX][KERNEL_MAX];

  logic [CC_W-1:0]  chan_cnt;
  logic [IMG_W-1:0] pic_rows;
  logic [IMG_W-1:0] pic_cols;
  logic [KER_W-1:0] ker_rows;
  logic [KER_W-1:0] ker_cols;
  logic [STR_W-1:0] step_rows;
  logic [STR_W-1:0] step_cols;

  out_point_t awaited_q [$];
  out_point_t want;
  int         fails = 0;
  int         outstanding = 0;

  assign fail_count_o  = fails;
  assign outstanding_o = outstanding;

  function automatic int clip(int v, int lim);
    return (v > lim) ? lim : v;
  endfunction

  // Registers above the store sizes saturate; a window off the image reports status.
  function automatic out_point_t window_sum(logic [POS_W-1:0] r, logic [POS_W-1:0] c);
    out_point_t              o;
    int                      nc, ir, ic, kr, kc, br, bc, ch, a, b;
    longint                  prod;
    logic signed [SUM_W-1:0] acc;
    nc  = clip(int'(chan_cnt), NUM_CH);
    ir  = clip(int'(pic_rows), NUM_ROWS);
    ic  = clip(int'(pic_cols), NUM_COLS);
    kr  = clip(int'(ker_rows), KERNEL_MAX);
    kc  = clip(int'(ker_cols), KERNEL_MAX);
    br  = int'(r) * int'(step_rows);
    bc  = int'(c) * int'(step_cols);
    acc = '0;
    o.out_row = r;
    o.out_col = c;
    o.status  = 1'b0;
    if (br + kr > ir || bc + kc > ic) begin
      o.status = 1'b1;
    end else begin
      for (ch = 0; ch < nc; ch++) begin
        for (a = 0; a < kr; a++) begin
          for (b = 0; b < kc; b++) begin
            prod = longint'(weight_mem[ch][a][b]) * longint'(pixel_mem[ch][br + a][bc + b]);
            acc  = acc + SUM_W'(prod);
          end
        end
      end
    end
    o.sum = acc;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt  = RST_CHANNEL_COUNT;
      pic_rows  = RST_IMAGE_ROWS;
      pic_cols  = RST_IMAGE_COLS;
      ker_rows  = RST_KERNEL_ROWS;
      ker_cols  = RST_KERNEL_COLS;
      step_rows = RST_STRIDE_ROWS;
      step_cols = RST_STRIDE_COLS;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CHANNEL_COUNT: chan_cnt  = cfg_data_i[CC_W-1:0];
          CFG_IMAGE_ROWS:    pic_rows  = cfg_data_i[IMG_W-1:0];
          CFG_IMAGE_COLS:    pic_cols  = cfg_data_i[IMG_W-1:0];
          CFG_KERNEL_ROWS:   ker_rows  = cfg_data_i[KER_W-1:0];
          CFG_KERNEL_COLS:   ker_cols  = cfg_data_i[KER_W-1:0];
          CFG_STRIDE_ROWS:   step_rows = cfg_data_i[STR_W-1:0];
          CFG_STRIDE_COLS:   step_cols = cfg_data_i[STR_W-1:0];
          default: ;
        endcase
      end

      // A result can never belong to a request taken at the same edge, so pop first.
      if (res_i.valid && res_i.ready) begin
        if (awaited_q.size() == 0) begin
          $display("%0t conv check: unexpected result row %0d col %0d sum %0d status %0d",
                   $time, res_i.out_row, res_i.out_col, res_i.sum, res_i.status);
          fails++;
        end else begin
          want = awaited_q.pop_front();
          if (res_i.out_row !== want.out_row || res_i.out_col !== want.out_col ||
              res_i.sum !== want.sum || res_i.status !== want.status) begin
            $display({"%0t conv check: expected row %0d col %0d sum %0d status %0d,",
                      " got row %0d col %0d sum %0d status %0d"},
                     $time, want.out_row, want.out_col, $signed(want.sum), want.status,
                     res_i.out_row, res_i.out_col, res_i.sum, res_i.status);
            fails++;
          end
        end
      end

      if (req_i.valid && req_i.ready) begin
        case (req_i.req_type)
          REQ_WEIGHT: begin
            if (req_i.row < KERNEL_MAX && req_i.col < KERNEL_MAX) begin
              weight_mem[req_i.channel][req_i.row][req_i.col] = req_i.value;
            end
          end
          REQ_PIXEL:   pixel_mem[req_i.channel][req_i.row][req_i.col] = req_i.value;
          REQ_COMPUTE: awaited_q.push_back(window_sum(req_i.row, req_i.col));
          default: ;
        endcase
      end
      outstanding = awaited_q.size();
    end
  end

endmodule

[tb/sv/tb_strided_multichannel_conv2d.sv]
// Top of the testbench for strided_multichannel_conv2d: clock, reset, stimulus and verdict.
// Drives weight, pixel and compute requests under several configurations and idle
// patterns; depends on smc2d_pkg, smc2d_if and the smc2d_checker module.
`timescale 1ns / 100ps
module tb_strided_multichannel_conv2d;
  import smc2d_pkg::*;

  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int SETTLE_CYCLES   = 10;
  localparam int TAIL_CYCLES     = 50;
  localparam int PHASE_ITEMS     = 20;
  localparam int RANDOM_PHASES   = 12;
  localparam int HOLD_OFF_CYCLES = 2000;
  localparam int STORE_CH        = 8;
  localparam int STORE_ROWS      = 32;
  localparam int STORE_COLS      = 32;
  localparam int STORE_K         = 7;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [VAL_W-1:0] VAL_MIN    = 16'h8000;
  localparam logic [VAL_W-1:0] VAL_MAX    = 16'h7fff;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int items_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  // Saturated view of the current configuration, used to pick windows.
  int cur_nc, cur_ir, cur_ic, cur_kr, cur_kc, cur_sr, cur_sc;

  // Store entries already written; no window may read any other.
  bit wgt_done [STORE_CH][STORE_K][STORE_K];
  bit pix_done [STORE_CH][STORE_ROWS][STORE_COLS];

  smc2d_req_if req_bus ();
  smc2d_res_if res_bus ();

  strided_multichannel_conv2d dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .req_i     (req_bus),
    .res_o     (res_bus)
  );

  smc2d_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .req_i        (req_bus),
    .res_i        (res_bus),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("strided_multichannel_conv2d: mismatch");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off counted down here.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      res_bus.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic int clip(int v, int lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Offers one item after a random gap and returns at the falling edge after its transfer.
  // Valid is left high so that the next item can follow without a bubble.
  task automatic send_req(logic [REQ_W-1:0] kind, logic [CH_W-1:0] ch,
                          logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                          logic [VAL_W-1:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.channel  <= ch;
    req_bus.row      <= r;
    req_bus.col      <= c;
    req_bus.value    <= v;
    do @(posedge clk); while (!req_bus.ready);
    @(negedge clk);
    if (kind != REQ_UNUSED && !(kind == REQ_WEIGHT && (r >= STORE_K || c >= STORE_K))) begin
      items_sent++;
    end
  endtask

  task automatic put_weight(logic [CH_W-1:0] ch, logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                            logic [VAL_W-1:0] v);
    send_req(REQ_WEIGHT, ch, r, c, v);
    if (r < STORE_K && c < STORE_K) begin
      wgt_done[ch][r][c] = 1'b1;
    end
  endtask

  task automatic put_pixel(logic [CH_W-1:0] ch, logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                           logic [VAL_W-1:0] v);
    send_req(REQ_PIXEL, ch, r, c, v);
    pix_done[ch][r][c] = 1'b1;
  endtask

  // Requests one output position, first writing any tap of the window not yet written.
  task automatic compute_at(logic [POS_W-1:0] r, logic [POS_W-1:0] c);
    int br, bc, ch, a, b;
    br = int'(r) * cur_sr;
    bc = int'(c) * cur_sc;
    if (br + cur_kr <= cur_ir && bc + cur_kc <= cur_ic) begin
      for (ch = 0; ch < cur_nc; ch++) begin
        for (a = 0; a < cur_kr; a++) begin
          for (b = 0; b < cur_kc; b++) begin
            if (!wgt_done[ch][a][b]) begin
              put_weight(CH_W'(ch), POS_W'(a), POS_W'(b), rand_value());
            end
            if (!pix_done[ch][br + a][bc + b]) begin
              put_pixel(CH_W'(ch), POS_W'(br + a), POS_W'(bc + b), rand_value());
            end
          end
        end
      end
    end
    send_req(REQ_COMPUTE, CH_W'($urandom), r, c, VAL_W'($urandom));
  endtask

  task automatic drain();
    req_bus.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  // Writes every register once the block has gone quiet.
  task automatic set_config(logic [CFG_DATA_W-1:0] cc, logic [CFG_DATA_W-1:0] ir,
                            logic [CFG_DATA_W-1:0] ic, logic [CFG_DATA_W-1:0] kr,
                            logic [CFG_DATA_W-1:0] kc, logic [CFG_DATA_W-1:0] sr,
                            logic [CFG_DATA_W-1:0] sc);
    drain();
    cfg_write(CFG_CHANNEL_COUNT, cc);
    cfg_write(CFG_IMAGE_ROWS, ir);
    cfg_write(CFG_IMAGE_COLS, ic);
    cfg_write(CFG_KERNEL_ROWS, kr);
    cfg_write(CFG_KERNEL_COLS, kc);
    cfg_write(CFG_STRIDE_ROWS, sr);
    cfg_write(CFG_STRIDE_COLS, sc);
    cfg_we <= 1'b0;
    cur_nc = clip(int'(cc[CC_W-1:0]), STORE_CH);
    cur_ir = clip(int'(ir[IMG_W-1:0]), STORE_ROWS);
    cur_ic = clip(int'(ic[IMG_W-1:0]), STORE_COLS);
    cur_kr = int'(kr[KER_W-1:0]);
    cur_kc = int'(kc[KER_W-1:0]);
    cur_sr = int'(sr[STR_W-1:0]);
    cur_sc = int'(sc[STR_W-1:0]);
  endtask

  initial begin : stimulus
    int                    phase, phase_end, pick, hi_r, hi_c, ch, a, b;
    logic [CFG_DATA_W-1:0] cc, ir, ic, kr, kc, sr, sc;
    logic [POS_W-1:0]      r, c;

    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_WEIGHT;
    req_bus.channel  = '0;
    req_bus.row      = '0;
    req_bus.col      = '0;
    req_bus.value    = '0;
    res_bus.ready    = 1'b0;
    cur_nc = int'(RST_CHANNEL_COUNT);
    cur_ir = int'(RST_IMAGE_ROWS);
    cur_ic = int'(RST_IMAGE_COLS);
    cur_kr = int'(RST_KERNEL_ROWS);
    cur_kc = int'(RST_KERNEL_COLS);
    cur_sr = int'(RST_STRIDE_ROWS);
    cur_sc = int'(RST_STRIDE_COLS);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset configuration: windows past the bottom and right edges, and dropped items.
    compute_at(5'd30, 5'd0);
    compute_at(5'd31, 5'd31);
    send_req(REQ_UNUSED, 3'd5, 5'd9, 5'd17, 16'h5a5a);
    put_weight(3'd7, 5'd31, 5'd31, VAL_MAX);

    // Single taps with the largest products of both signs, corner positions.
    set_config(6'd1, 6'd32, 6'd32, 6'd1, 6'd1, 6'd1, 6'd1);
    put_weight(3'd0, 5'd0, 5'd0, VAL_MIN);
    put_pixel(3'd0, 5'd0, 5'd0, VAL_MIN);
    compute_at(5'd0, 5'd0);
    put_pixel(3'd0, 5'd31, 5'd31, VAL_MAX);
    compute_at(5'd31, 5'd31);
    put_weight(3'd0, 5'd0, 5'd0, VAL_MAX);
    compute_at(5'd31, 5'd31);
    put_pixel(3'd7, 5'd31, 5'd31, VAL_MIN);
    put_weight(3'd7, 5'd6, 5'd6, VAL_MAX);

    // No channels, then an empty kernel: both sum to zero.
    set_config(6'd0, 6'd32, 6'd32, 6'd1, 6'd1, 6'd1, 6'd1);
    compute_at(5'd5, 5'd5);
    set_config(6'd1, 6'd32, 6'd32, 6'd0, 6'd1, 6'd1, 6'd1);
    compute_at(5'd3, 5'd3);

    // Zero stride puts every window at the origin.
    set_config(6'd1, 6'd32, 6'd32, 6'd1, 6'd1, 6'd0, 6'd0);
    compute_at(5'd31, 5'd31);

    // All ones: sizes saturate, stride 15 pushes the window off the image.
    set_config(6'h3f, 6'h3f, 6'h3f, 6'h3f, 6'h3f, 6'h3f, 6'h3f);
    compute_at(5'd2, 5'd0);
    compute_at(5'd0, 5'd2);

    // Kernel larger than the image.
    set_config(6'd1, 6'd2, 6'd2, 6'd3, 6'd3, 6'd1, 6'd1);
    compute_at(5'd0, 5'd0);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      // Mostly small shapes keep window fills short; a few reach further.
      cc = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(4, 8))   : 6'($urandom_range(1, 3));
      ir = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(13, 32)) : 6'($urandom_range(1, 12));
      ic = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(13, 32)) : 6'($urandom_range(1, 12));
      kr = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(4, 5))   : 6'($urandom_range(1, 3));
      kc = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(4, 5))   : 6'($urandom_range(1, 3));
      sr = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 8))   : 6'($urandom_range(1, 3));
      sc = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 8))   : 6'($urandom_range(1, 3));
      set_config(cc, ir, ic, kr, kc, sr, sc);
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      // The sender keeps offering while results back up behind a long hold-off: the
      // first result waits in the output register, the second holds the block, and the
      // third request is refused until the hold-off ends.
      if (phase == 4) begin
        hold_cycles = HOLD_OFF_CYCLES;
        repeat (3) compute_at(5'd0, 5'd0);
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        r    = POS_W'($urandom);
        c    = POS_W'($urandom);
        if (pick < 40) begin
          if (cur_kr <= cur_ir && cur_kc <= cur_ic) begin
            hi_r = (cur_sr == 0) ? STORE_ROWS - 1 : clip((cur_ir - cur_kr) / cur_sr, 31);
            hi_c = (cur_sc == 0) ? STORE_COLS - 1 : clip((cur_ic - cur_kc) / cur_sc, 31);
            r    = POS_W'($urandom_range(0, hi_r));
            c    = POS_W'($urandom_range(0, hi_c));
          end
          compute_at(r, c);
        end else if (pick < 50) begin
          compute_at(r, c);
        end else if (pick < 72) begin
          if ($urandom_range(0, 4) != 0) begin
            r = POS_W'($urandom_range(0, STORE_K - 1));
            c = POS_W'($urandom_range(0, STORE_K - 1));
          end
          put_weight(CH_W'($urandom), r, c, rand_value());
        end else if (pick < 95) begin
          ch = ($urandom_range(0, 1) == 0) ? $urandom_range(0, STORE_CH - 1)
                                           : $urandom_range(0, clip(cur_nc, 8) - 1 + (cur_nc == 0));
          if ($urandom_range(0, 4) != 0) begin
            r = POS_W'($urandom_range(0, (cur_ir == 0) ? 0 : cur_ir - 1));
            c = POS_W'($urandom_range(0, (cur_ic == 0) ? 0 : cur_ic - 1));
          end
          put_pixel(CH_W'(ch), r, c, rand_value());
        end else begin
          send_req(REQ_UNUSED, CH_W'($urandom), r, c, VAL_W'($urandom));
        end
      end
    end

    // Largest window: eight channels of a 7 by 7 kernel, products near the top of the sum.
    set_config(6'd8, 6'd7, 6'd7, 6'd7, 6'd7, 6'd1, 6'd1);
    idle_pct  = 25;
    stall_pct = 25;
    for (ch = 0; ch < STORE_CH; ch++) begin
      for (a = 0; a < STORE_K; a++) begin
        for (b = 0; b < STORE_K; b++) begin
          put_weight(CH_W'(ch), POS_W'(a), POS_W'(b), VAL_MIN);
          put_pixel(CH_W'(ch), POS_W'(a), POS_W'(b), VAL_MIN);
        end
      end
    end
    compute_at(5'd0, 5'd0);
    for (a = 0; a < STORE_K; a++) begin
      for (b = 0; b < STORE_K; b++) begin
        put_pixel(3'd0, POS_W'(a), POS_W'(b), VAL_MAX);
      end
    end
    compute_at(5'd0, 5'd0);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("strided_multichannel_conv2d: match");
    end else begin
      $display("strided_multichannel_conv2d: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
design/smc2d_pkg.sv
design/smc2d_if.sv
design/smc2d_ram.sv
design/strided_multichannel_conv2d.sv
design/smc2d_chk.sv
tb/sv/smc2d_checker.sv
tb/sv/tb_strided_multichannel_conv2d.sv
